>>> design/grc_pkg.sv
// grc_pkg: shared constants and types for the grid ray caster
// no dependencies

package grc_pkg;

   localparam int MAP_SIDE  = 32;
   localparam int SCREEN_W  = 256;
   localparam int SCREEN_H  = 256;
   localparam int MAX_STEPS = 64;
   localparam int TEX_SIZE  = 32;

   localparam int MAP_W    = $clog2(MAP_SIDE);
   localparam int MAP_AW   = $clog2(MAP_SIDE * MAP_SIDE);
   localparam int CELL_W   = 6;
   localparam int COORD_W  = MAP_W + 2;
   localparam int STEP_W   = $clog2(MAX_STEPS + 1);
   localparam int DIV_W    = 40;
   localparam int DIVR_W   = 24;
   localparam int DIST_MAX = 16777215;
   localparam int LH_MAX   = 65535;
   localparam int ONE_Q16  = 65536;

   localparam logic OP_CAST  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   typedef enum logic [2:0] {
      REG_CAMERA_POS_X = 3'd0,
      REG_CAMERA_POS_Y = 3'd1,
      REG_VIEW_DIR_X   = 3'd2,
      REG_VIEW_DIR_Y   = 3'd3,
      REG_VIEW_PLANE_X = 3'd4,
      REG_VIEW_PLANE_Y = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic              en;
      logic [MAP_AW-1:0] addr;
      logic [CELL_W-1:0] data;
   } map_wr_type;

endpackage

>>> design/grid_raycast_column.sv
// grid_raycast_column: top level, register file, cast sequencer and result stage
// depends on grc_pkg, grc_tile_mem, grc_divider
//
// usage: a transaction on start with req_operation OP_WRITE writes one map cell;
// busy stays low. a cast transaction raises busy on the next cycle and a single
// rsp_valid cycle carries the result.
// the four divisions, two deltas, the wall distance and the line height, run one
// after another on the shared serial divider. a walk passes each cell through a
// step state (map read) and a check state (test). a zero ray component or a wall
// distance found without dividing skips its own division, a zero distance also
// skips the line height division, and a miss skips both of the last two. the next
// transaction can be taken in the cycle that carries the result.
// results are shown for exactly one cycle; the receiver cannot stall, so
// nothing is held back. csr writes are taken in any cycle and act at once.
// after reset the tile map is swept to zero, one cell per cycle, over all
// MAP_SIDE*MAP_SIDE (1024) cells; busy is high during the sweep.

module grid_raycast_column import grc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_operation,
   input  logic [7:0]  req_column,
   input  logic [4:0]  req_cell_x,
   input  logic [4:0]  req_cell_y,
   input  logic [5:0]  req_cell_value,
   output logic        rsp_valid,
   output logic [5:0]  rsp_hit_value,
   output logic        rsp_hit_side,
   output logic [23:0] rsp_wall_distance,
   output logic [15:0] rsp_line_height,
   output logic [7:0]  rsp_draw_start,
   output logic [7:0]  rsp_draw_end,
   output logic [4:0]  rsp_tex_column,
   output logic        rsp_no_hit,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [20:0] csr_write_data
);

   localparam int RW    = 21;
   localparam int NW    = COORD_W + 17;
   localparam int DD_W  = 41;
   localparam int HALF_H = SCREEN_H / 2;

   typedef enum logic [4:0] {
      S_IDLE, S_CAM, S_MUL, S_RAY, S_DXGO, S_DXW, S_DYGO, S_DYW, S_SIDE,
      S_STEP, S_CHECK, S_DGO, S_DW, S_LGO, S_LW, S_TEX, S_OUT, S_MISS
   } state_type;

   state_type state_ff;

   logic [20:0] pos_x_ff, pos_y_ff;
   logic signed [17:0] dir_x_ff, dir_y_ff, plane_x_ff, plane_y_ff;

   logic [7:0]          col_ff;
   logic signed [17:0]  cam_ff;
   logic signed [35:0]  prodx_ff, prody_ff;
   logic signed [RW-1:0] rx_ff, ry_ff;
   logic [32:0]         dx_ff, dy_ff;
   logic [DD_W-1:0]     ddx_ff, ddy_ff;
   logic signed [COORD_W-1:0] mx_ff, my_ff;
   logic [STEP_W-1:0]   n_ff;
   logic                side_ff;
   logic [CELL_W-1:0]   val_ff;
   logic [23:0]         dist_ff;
   logic [15:0]         lh_ff;
   logic signed [45:0]  wprod_ff;

   logic        rsp_valid_ff, rsp_side_ff, rsp_no_hit_ff;
   logic [5:0]  rsp_val_ff;
   logic [23:0] rsp_dist_ff;
   logic [15:0] rsp_lh_ff;
   logic [7:0]  rsp_ds_ff, rsp_de_ff;
   logic [4:0]  rsp_tex_ff;

   map_wr_type        map_wr;
   logic [MAP_AW-1:0] rd_addr;
   logic [CELL_W-1:0] rd_data;
   logic              clearing;

   logic              div_start;
   logic [DIV_W-1:0]  div_dividend;
   logic [DIVR_W-1:0] div_divisor;
   logic [DIV_W-1:0]  div_q;
   logic              div_done;

   logic              accept;
   logic [24:0]       cam_u;
   logic [RW-1:0]     mag_x, mag_y;
   logic [16:0]       fac_x, fac_y;
   logic              xinf, yinf, xstep;
   logic signed [COORD_W-1:0] mx_nx, my_nx;
   logic              out_map;
   logic signed [NW-1:0] num;
   logic signed [RW-1:0] den;
   logic [NW-1:0]     num_mag;
   logic [RW-1:0]     den_mag;
   logic [15:0]       frac;
   logic [31:0]       tex_a, tex_b, tex_c;
   logic [16:0]       half;
   logic [16:0]       ds_v, de_v;

   assign accept = start && !busy;
   assign busy   = clearing || (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
         dir_x_ff   <= -18'sd65536;
         dir_y_ff   <= '0;
         plane_x_ff <= '0;
         plane_y_ff <= 18'sd43254;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_CAMERA_POS_X: pos_x_ff   <= csr_write_data;
            REG_CAMERA_POS_Y: pos_y_ff   <= csr_write_data;
            REG_VIEW_DIR_X:   dir_x_ff   <= csr_write_data[17:0];
            REG_VIEW_DIR_Y:   dir_y_ff   <= csr_write_data[17:0];
            REG_VIEW_PLANE_X: plane_x_ff <= csr_write_data[17:0];
            REG_VIEW_PLANE_Y: plane_y_ff <= csr_write_data[17:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      map_wr.en   = accept && (req_operation == OP_WRITE) &&
                    (32'(req_cell_x) < MAP_SIDE) && (32'(req_cell_y) < MAP_SIDE);
      map_wr.addr = MAP_AW'(32'(req_cell_y) * MAP_SIDE + 32'(req_cell_x));
      map_wr.data = req_cell_value;
   end

   assign cam_u = ({17'b0, col_ff} << 17) / 25'(SCREEN_W);
   assign mag_x = rx_ff[RW-1] ? RW'(-rx_ff) : RW'(rx_ff);
   assign mag_y = ry_ff[RW-1] ? RW'(-ry_ff) : RW'(ry_ff);
   assign fac_x = rx_ff[RW-1] ? {1'b0, pos_x_ff[15:0]} : 17'(ONE_Q16) - {1'b0, pos_x_ff[15:0]};
   assign fac_y = ry_ff[RW-1] ? {1'b0, pos_y_ff[15:0]} : 17'(ONE_Q16) - {1'b0, pos_y_ff[15:0]};
   assign xinf  = (rx_ff == '0);
   assign yinf  = (ry_ff == '0);
   assign xstep = !xinf && (yinf || (ddx_ff < ddy_ff));
   assign mx_nx = xstep ? (rx_ff[RW-1] ? mx_ff - 1'b1 : mx_ff + 1'b1) : mx_ff;
   assign my_nx = xstep ? my_ff : (ry_ff[RW-1] ? my_ff - 1'b1 : my_ff + 1'b1);
   assign out_map = (mx_nx < 0) || (my_nx < 0) ||
                    (mx_nx >= COORD_W'(MAP_SIDE)) || (my_nx >= COORD_W'(MAP_SIDE));
   assign rd_addr = MAP_AW'(32'(my_nx[MAP_W-1:0]) * MAP_SIDE + 32'(mx_nx[MAP_W-1:0]));

   always_comb begin
      if (side_ff) begin
         num = {my_ff[COORD_W-1], my_ff, 16'b0} - NW'({1'b0, pos_y_ff})
               + (ry_ff[RW-1] ? NW'(ONE_Q16) : NW'(0));
         den = ry_ff;
      end else begin
         num = {mx_ff[COORD_W-1], mx_ff, 16'b0} - NW'({1'b0, pos_x_ff})
               + (rx_ff[RW-1] ? NW'(ONE_Q16) : NW'(0));
         den = rx_ff;
      end
      num_mag = num[NW-1] ? NW'(-num) : NW'(num);
      den_mag = den[RW-1] ? RW'(-den) : RW'(den);
   end

   always_comb begin
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      case (state_ff)
         S_DXGO: begin
            div_start    = !xinf;
            div_dividend = DIV_W'(64'h1_0000_0000);
            div_divisor  = DIVR_W'(mag_x);
         end
         S_DYGO: begin
            div_start    = !yinf;
            div_dividend = DIV_W'(64'h1_0000_0000);
            div_divisor  = DIVR_W'(mag_y);
         end
         S_DGO: begin
            div_start    = (den != '0) && !((num[NW-1] != den[RW-1]) && (num != '0));
            div_dividend = DIV_W'({num_mag, 16'b0});
            div_divisor  = DIVR_W'(den_mag);
         end
         S_LGO: begin
            div_start    = (dist_ff != '0);
            div_dividend = DIV_W'(64'(SCREEN_H) << 16);
            div_divisor  = dist_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      frac  = (side_ff ? pos_x_ff[15:0] : pos_y_ff[15:0]) + wprod_ff[31:16];
      tex_a = ({16'b0, frac} * 32'(TEX_SIZE)) >> 16;
      tex_b = ((!side_ff && !rx_ff[RW-1] && !xinf) || (side_ff && ry_ff[RW-1]))
              ? 32'(TEX_SIZE) - tex_a - 32'd1 : tex_a;
      tex_c = (tex_b * 32'd32) / 32'(TEX_SIZE);
      half  = {2'b0, lh_ff[15:1]};
      ds_v  = (half > 17'(HALF_H)) ? 17'd0 : 17'(HALF_H) - half;
      de_v  = (17'(HALF_H) + half >= 17'(SCREEN_H)) ? 17'(SCREEN_H - 1)
                                                     : 17'(HALF_H) + half;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == S_OUT) || (state_ff == S_MISS);
         case (state_ff)
            S_IDLE: begin
               if (accept && (req_operation == OP_CAST)) begin
                  col_ff   <= req_column;
                  state_ff <= S_CAM;
               end
            end
            S_CAM: begin
               cam_ff   <= $signed({1'b0, cam_u[16:0]}) - 18'sd65536;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               prodx_ff <= plane_x_ff * cam_ff;
               prody_ff <= plane_y_ff * cam_ff;
               state_ff <= S_RAY;
            end
            S_RAY: begin
               rx_ff    <= RW'(dir_x_ff) + {prodx_ff[35], prodx_ff[35:16]};
               ry_ff    <= RW'(dir_y_ff) + {prody_ff[35], prody_ff[35:16]};
               mx_ff    <= COORD_W'(pos_x_ff[20:16]);
               my_ff    <= COORD_W'(pos_y_ff[20:16]);
               n_ff     <= '0;
               side_ff  <= 1'b0;
               state_ff <= S_DXGO;
            end
            S_DXGO: begin
               dx_ff    <= '0;
               state_ff <= xinf ? S_DYGO : S_DXW;
            end
            S_DXW: begin
               if (div_done) begin
                  dx_ff    <= div_q[32:0];
                  state_ff <= S_DYGO;
               end
            end
            S_DYGO: begin
               dy_ff    <= '0;
               state_ff <= yinf ? S_SIDE : S_DYW;
            end
            S_DYW: begin
               if (div_done) begin
                  dy_ff    <= div_q[32:0];
                  state_ff <= S_SIDE;
               end
            end
            S_SIDE: begin
               ddx_ff   <= DD_W'((50'(fac_x) * 50'(dx_ff)) >> 16);
               ddy_ff   <= DD_W'((50'(fac_y) * 50'(dy_ff)) >> 16);
               state_ff <= S_STEP;
            end
            S_STEP: begin
               if (xstep) begin
                  ddx_ff  <= ddx_ff + DD_W'(dx_ff);
                  side_ff <= 1'b0;
               end else begin
                  ddy_ff  <= ddy_ff + DD_W'(dy_ff);
                  side_ff <= 1'b1;
               end
               mx_ff    <= mx_nx;
               my_ff    <= my_nx;
               n_ff     <= n_ff + 1'b1;
               state_ff <= out_map ? S_MISS : S_CHECK;
            end
            S_CHECK: begin
               val_ff <= rd_data;
               if (rd_data != '0) begin
                  state_ff <= S_DGO;
               end else if (n_ff == STEP_W'(MAX_STEPS)) begin
                  state_ff <= S_MISS;
               end else begin
                  state_ff <= S_STEP;
               end
            end
            S_DGO: begin
               if (den == '0) begin
                  dist_ff  <= 24'(DIST_MAX);
                  state_ff <= S_LGO;
               end else if ((num[NW-1] != den[RW-1]) && (num != '0)) begin
                  dist_ff  <= '0;
                  state_ff <= S_LGO;
               end else begin
                  state_ff <= S_DW;
               end
            end
            S_DW: begin
               if (div_done) begin
                  dist_ff  <= (div_q > DIV_W'(DIST_MAX)) ? 24'(DIST_MAX) : div_q[23:0];
                  state_ff <= S_LGO;
               end
            end
            S_LGO: begin
               lh_ff    <= 16'(LH_MAX);
               state_ff <= (dist_ff == '0) ? S_TEX : S_LW;
            end
            S_LW: begin
               if (div_done) begin
                  lh_ff    <= (div_q > DIV_W'(LH_MAX)) ? 16'(LH_MAX) : div_q[15:0];
                  state_ff <= S_TEX;
               end
            end
            S_TEX: begin
               wprod_ff <= $signed({1'b0, dist_ff}) * (side_ff ? rx_ff : ry_ff);
               state_ff <= S_OUT;
            end
            S_OUT: begin
               rsp_no_hit_ff <= 1'b0;
               rsp_val_ff    <= val_ff;
               rsp_side_ff   <= side_ff;
               rsp_dist_ff   <= dist_ff;
               rsp_lh_ff     <= lh_ff;
               rsp_ds_ff     <= ds_v[7:0];
               rsp_de_ff     <= de_v[7:0];
               rsp_tex_ff    <= tex_c[4:0];
               state_ff      <= S_IDLE;
            end
            S_MISS: begin
               rsp_no_hit_ff <= 1'b1;
               rsp_val_ff    <= '0;
               rsp_side_ff   <= 1'b0;
               rsp_dist_ff   <= '0;
               rsp_lh_ff     <= '0;
               rsp_ds_ff     <= '0;
               rsp_de_ff     <= '0;
               rsp_tex_ff    <= '0;
               state_ff      <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   grc_tile_mem u_mem (
      .clock    (clock),
      .reset    (reset),
      .wr       (map_wr),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .clearing (clearing)
   );

   grc_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_q),
      .done     (div_done)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit_value     = rsp_val_ff;
   assign rsp_hit_side      = rsp_side_ff;
   assign rsp_wall_distance = rsp_dist_ff;
   assign rsp_line_height   = rsp_lh_ff;
   assign rsp_draw_start    = rsp_ds_ff;
   assign rsp_draw_end      = rsp_de_ff;
   assign rsp_tex_column    = rsp_tex_ff;
   assign rsp_no_hit        = rsp_no_hit_ff;

   // a cast transaction keeps the block busy until its result
   a_cast_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_operation == OP_CAST) |=> busy)
      else $error("cast accepted but block not busy");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_hit |-> rsp_hit_value == '0 && rsp_wall_distance == '0)
      else $error("miss result carries data");

   a_hit_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_no_hit |-> rsp_hit_value != '0 && rsp_draw_start <= rsp_draw_end)
      else $error("hit result inconsistent");

endmodule

>>> design/grc_tile_mem.sv
// grc_tile_mem: tile map storage, one write and one registered read port
// clears itself after reset; depends on grc_pkg

module grc_tile_mem import grc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  map_wr_type        wr,
   input  logic [MAP_AW-1:0] rd_addr,
   output logic [CELL_W-1:0] rd_data,
   output logic              clearing
);

   logic [CELL_W-1:0] mem [MAP_SIDE*MAP_SIDE];
   logic [MAP_AW-1:0] clr_ff;
   logic              clearing_ff;
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         clearing_ff <= 1'b1;
      end else if (clearing_ff) begin
         clr_ff <= clr_ff + 1'b1;
         if (clr_ff == MAP_AW'(MAP_SIDE*MAP_SIDE-1)) clearing_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_ff] <= '0;
      end else if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clearing_ff;

endmodule

>>> design/grc_divider.sv
// grc_divider: unsigned restoring divider, one quotient bit per cycle
// depends on grc_pkg

module grc_divider import grc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [DIVR_W-1:0] divisor,
   output logic [DIV_W-1:0]  quotient,
   output logic              done
);

   localparam int CNT_W = $clog2(DIV_W);

   logic [DIVR_W:0]   rem_ff;
   logic [DIV_W-1:0]  q_ff;
   logic [DIVR_W-1:0] dvr_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              run_ff;
   logic              done_ff;
   logic [DIVR_W:0]   shifted;
   logic              fits;

   assign shifted = {rem_ff[DIVR_W-1:0], q_ff[DIV_W-1]};
   assign fits    = shifted >= {1'b0, dvr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !start && run_ff && (cnt_ff == CNT_W'(DIV_W-1));
         if (start) begin
            rem_ff <= '0;
            q_ff   <= dividend;
            dvr_ff <= divisor;
            cnt_ff <= '0;
            run_ff <= 1'b1;
         end else if (run_ff) begin
            rem_ff <= fits ? shifted - {1'b0, dvr_ff} : shifted;
            q_ff   <= {q_ff[DIV_W-2:0], fits};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_W-1)) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   assign quotient = q_ff;
   assign done     = done_ff;

endmodule
